FILE: rtl/core/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN
    } state_t;

    typedef enum logic [2:0] {
        RES_OK,
        RES_EMPTY,
        RES_FULL,
        RES_POP,
        RES_FOUND
    } res_kind_t;

    typedef struct packed {
        logic      in_take;
        logic      push;
        logic      rd_start;
        logic      scan_step;
        logic      pop_done;
        logic      clear;
        logic      res_load;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic is_empty;
        logic is_full;
        logic match;
        logic scan_last;
        logic out_free;
    } dp_sts_t;

    // ring index: base + off, both below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] off
    );
        logic [CNT_W-1:0] sum;
        sum = CNT_W'(base) + CNT_W'(off);
        if (sum >= DEPTH_C)
        begin
            sum = sum - DEPTH_C;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/core/bdq_ifs.sv
interface bdq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               found;
    logic [3:0]         position;
    logic [4:0]         entry_count;
    logic               is_empty;

    modport source (
        output valid, output status, output out_value, output found,
        output position, output entry_count, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input out_value, input found,
        input position, input entry_count, input is_empty, output ready
    );
endinterface

FILE: rtl/core/bdq_ram.sv
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/bdq_ctrl.sv
module bdq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bdq_pkg::dp_sts_t sts,
    output bdq_pkg::dp_cmd_t cmd
);
    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_take = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.res_load = 1'b1;
                            if (sts.is_full)
                            begin
                                cmd.res_kind = RES_FULL;
                            end
                            else
                            begin
                                cmd.push     = 1'b1;
                                cmd.res_kind = RES_OK;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK:
                    begin
                        if (sts.is_empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.res_kind = RES_EMPTY;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_POP;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (sts.is_empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.res_kind = RES_OK;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.clear    = 1'b1;
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_OK;
                            state_next   = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_OK;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP:
            begin
                if (sts.out_free)
                begin
                    cmd.pop_done = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_POP;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                priority if (sts.match)
                begin
                    if (sts.out_free)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RES_FOUND;
                        state_next   = S_IDLE;
                    end
                end
                else if (sts.scan_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RES_OK;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/bdq_dp.sv
module bdq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [2:0]                    in_cmd,
    input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [1:0]                    out_status,
    output logic signed [bdq_pkg::DATA_W-1:0] out_value,
    output logic                          out_found,
    output logic [bdq_pkg::IDX_W-1:0]     out_position,
    output logic [bdq_pkg::CNT_W-1:0]     out_count,
    output logic                          out_empty,
    input  bdq_pkg::dp_cmd_t              cmd,
    output bdq_pkg::dp_sts_t              sts
);
    import bdq_pkg::*;

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]  front_reg;
    logic [IDX_W-1:0]  front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  scan_next;

    logic              res_valid_reg;
    status_t           res_status_reg;
    logic [DATA_W-1:0] res_value_reg;
    logic              res_found_reg;
    logic [IDX_W-1:0]  res_pos_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic              res_empty_reg;

    logic [IDX_W-1:0]  front_dec;
    logic [IDX_W-1:0]  front_inc;
    logic [IDX_W-1:0]  count_m1;
    logic [IDX_W-1:0]  scan_inc;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              is_front_op;
    status_t           res_status;

    assign is_front_op = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_POP_FRONT);
    assign front_dec   = ring_add(front_reg, IDX_W'(DEPTH - 1));
    assign front_inc   = ring_add(front_reg, IDX_W'(1));
    assign count_m1    = IDX_W'(count_reg - CNT_W'(1));
    assign scan_inc    = scan_reg + IDX_W'(1);

    assign wr_en   = cmd.push;
    assign wr_addr = is_front_op ? front_dec : ring_add(front_reg, count_reg[IDX_W-1:0]);

    assign rd_en = cmd.rd_start || cmd.scan_step;

    always_comb
    begin
        rd_addr = front_reg;
        if (cmd.scan_step)
        begin
            rd_addr = ring_add(front_reg, scan_inc);
        end
        else if (cmd_reg == CMD_POP_BACK)
        begin
            rd_addr = ring_add(front_reg, count_m1);
        end
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        if (cmd.clear)
        begin
            front_next = '0;
            count_next = '0;
        end
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            if (is_front_op)
            begin
                front_next = front_dec;
            end
        end
        if (cmd.pop_done)
        begin
            count_next = count_reg - CNT_W'(1);
            if (is_front_op)
            begin
                front_next = front_inc;
            end
        end
        if (cmd.rd_start)
        begin
            scan_next = '0;
        end
        if (cmd.scan_step)
        begin
            scan_next = scan_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            if (cmd.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.res_kind)
            RES_EMPTY: res_status = ST_EMPTY;
            RES_FULL:  res_status = ST_FULL;
            default:   res_status = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (cmd.in_take)
        begin
            cmd_reg   <= cmd_t'(in_cmd);
            value_reg <= in_value;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= res_status;
            res_value_reg  <= (cmd.res_kind == RES_POP) ? rd_data : '0;
            res_found_reg  <= (cmd.res_kind == RES_FOUND);
            res_pos_reg    <= (cmd.res_kind == RES_FOUND) ? scan_reg : '0;
            res_count_reg  <= count_next;
            res_empty_reg  <= (count_next == '0);
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.is_empty  = (count_reg == '0);
    assign sts.is_full   = (count_reg == DEPTH_C);
    assign sts.match     = (rd_data == value_reg);
    assign sts.scan_last = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);
    assign sts.out_free  = !res_valid_reg || out_ready;

    assign out_valid    = res_valid_reg;
    assign out_status   = res_status_reg;
    assign out_value    = res_value_reg;
    assign out_found    = res_found_reg;
    assign out_position = res_pos_reg;
    assign out_count    = res_count_reg;
    assign out_empty    = res_empty_reg;

endmodule

FILE: rtl/core/bounded_deque_with_search.sv
// Push, clear and rejected commands load the result register from the exec state;
// a pop loads it from the pop state after a registered RAM read; a find loads it
// on a match or when the last entry misses; one ring entry is compared per cycle.
// One command in flight; the next beat is taken the cycle after the result is loaded.
// Reset empties the queue (front and count to zero) and drops any pending result;
// the ring store itself is not cleared.
module bounded_deque_with_search (
    input logic       clk,
    input logic       rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);
    import bdq_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    bdq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_cmd       (req.cmd),
        .in_value     (req.value),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_status   (rsp.status),
        .out_value    (rsp.out_value),
        .out_found    (rsp.found),
        .out_position (rsp.position),
        .out_count    (rsp.entry_count),
        .out_empty    (rsp.is_empty),
        .cmd          (dp_cmd),
        .sts          (dp_sts)
    );

endmodule

FILE: rtl/core/bdq_checker.sv
module bdq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_out_value,
    input logic        rsp_found,
    input logic [3:0]  rsp_position,
    input logic [4:0]  rsp_entry_count,
    input logic        rsp_is_empty
);
    import bdq_pkg::*;

    // one command in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a command is in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
            && $stable(rsp_entry_count) && $stable(rsp_status))
        else $error("stalled response beat changed");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0))
            && (rsp_entry_count <= DEPTH_C))
        else $error("entry count and empty flag disagree");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_out_value == '0) && !rsp_found)
        else $error("rejected command carries data");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> (rsp_position == '0))
        else $error("position set without a match");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_out_value   (rsp.out_value),
    .rsp_found       (rsp.found),
    .rsp_position    (rsp.position),
    .rsp_entry_count (rsp.entry_count),
    .rsp_is_empty    (rsp.is_empty)
);
